### hdl/bitmap_page_allocator_defines.svh
// Assertion macros used by the bitmap page allocator checker.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bpa_pkg.sv
// Types and constants of the bitmap page allocator.
package bpa_pkg;

    localparam int PAGES      = 1024;
    localparam int PAGE_W     = 10;
    localparam int CNT_W      = 11;
    localparam int SHIFT_W    = 5;
    localparam int MAX_SHIFT  = 16;
    localparam int OFF_W      = 26;
    localparam int BOUND_W    = CNT_W + MAX_SHIFT;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;
    localparam logic [CNT_W-1:0]   RESET_PAGES = 11'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'b1;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_ALIGN = 2'd3;

    typedef struct packed {
        logic             mode;
        logic [OFF_W-1:0] byte_offset;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] page_index;
        logic [OFF_W-1:0]  page_address;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_SCAN,
        S_NEXT_RD,
        S_NEXT_SCAN,
        S_FREE_CHECK,
        S_FREE_RD,
        S_FREE_COMMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic alloc_scan;
        logic alloc_fail;
        logic next_scan;
        logic next_fail;
        logic free_check;
        logic free_err;
        logic free_commit;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic last_word;
        logic range_err;
        logic align_err;
    } dp_stat_t;

endpackage

### hdl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bpa_datapath.sv
// Datapath: configuration, bitmap store, word scan and result registers.
module bpa_datapath #(
    parameter int WORD_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bpa_pkg::req_t                       req,
    input  logic                                cfg_write,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  bpa_pkg::dp_cmd_t                    cmd,
    output bpa_pkg::dp_stat_t                   stat,
    output logic                                done,
    output bpa_pkg::rsp_t                       result
);

    localparam int WB_W   = $clog2(WORD_BITS);
    localparam int NWORDS = bpa_pkg::PAGES / WORD_BITS;
    localparam int PTR_W  = bpa_pkg::PAGE_W - WB_W;

    logic [bpa_pkg::SHIFT_W-1:0] shift_cfg_reg;
    logic [bpa_pkg::CNT_W-1:0]   pages_cfg_reg;
    bpa_pkg::req_t               req_reg,        req_next;
    logic [bpa_pkg::SHIFT_W-1:0] shift_reg,      shift_next;
    logic [bpa_pkg::CNT_W-1:0]   limit_reg,      limit_next;
    logic [PTR_W-1:0]            ptr_reg,        ptr_next;
    logic [bpa_pkg::PAGE_W-1:0]  page_reg,       page_next;
    logic [bpa_pkg::PAGE_W-1:0]  first_free_reg, first_free_next;
    logic                        none_free_reg,  none_free_next;
    logic [NWORDS-1:0]           word_valid_reg, word_valid_next;
    bpa_pkg::rsp_t               rsp_reg,        rsp_next;
    logic                        done_reg,       done_next;

    logic [bpa_pkg::SHIFT_W-1:0] eff_shift;
    logic [bpa_pkg::CNT_W-1:0]   eff_limit;
    logic [bpa_pkg::CNT_W-1:0]   base;
    logic [bpa_pkg::CNT_W-1:0]   rem;
    logic                        in_word;
    logic [WORD_BITS-1:0]        limit_mask;
    logic [WORD_BITS-1:0]        rdata;
    logic [WORD_BITS-1:0]        word_data;
    logic [WORD_BITS-1:0]        scan_word;
    logic [WB_W-1:0]             zbit;
    logic                        found;
    logic [bpa_pkg::PAGE_W-1:0]  scan_page;
    logic [bpa_pkg::BOUND_W-1:0] bound;
    logic [bpa_pkg::OFF_W-1:0]   low_mask;
    logic [bpa_pkg::PAGE_W-1:0]  free_page;
    logic [bpa_pkg::OFF_W-1:0]   page_addr;
    logic                        ram_we;
    logic [WORD_BITS-1:0]        ram_wdata;

    // Clamp configuration to the supported range
    always_comb
    begin
        eff_shift = (shift_cfg_reg > bpa_pkg::SHIFT_W'(bpa_pkg::MAX_SHIFT))
                    ? bpa_pkg::SHIFT_W'(bpa_pkg::MAX_SHIFT) : shift_cfg_reg;
        if (pages_cfg_reg == '0)
        begin
            eff_limit = bpa_pkg::CNT_W'(1);
        end
        else if (pages_cfg_reg > bpa_pkg::CNT_W'(bpa_pkg::PAGES))
        begin
            eff_limit = bpa_pkg::CNT_W'(bpa_pkg::PAGES);
        end
        else
        begin
            eff_limit = pages_cfg_reg;
        end
    end

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NWORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    // Word scan: pages at or past the limit count as busy
    always_comb
    begin
        base    = bpa_pkg::CNT_W'({ptr_reg, {WB_W{1'b0}}});
        rem     = limit_reg - base;
        in_word = limit_reg > base;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            limit_mask[i] = !in_word || (bpa_pkg::CNT_W'(i) >= rem);
        end
        word_data = word_valid_reg[ptr_reg] ? rdata : '0;
        scan_word = word_data | limit_mask;
        found     = !(&scan_word);
        zbit      = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!scan_word[i])
            begin
                zbit = WB_W'(i);
            end
        end
        scan_page = {ptr_reg, zbit};
    end

    // Free request checks
    always_comb
    begin
        bound     = bpa_pkg::BOUND_W'(limit_reg) << shift_reg;
        low_mask  = (bpa_pkg::OFF_W'(1) << shift_reg) - bpa_pkg::OFF_W'(1);
        free_page = bpa_pkg::PAGE_W'(req_reg.byte_offset >> shift_reg);
        page_addr = bpa_pkg::OFF_W'(page_reg) << shift_reg;
    end

    assign stat.found     = found;
    assign stat.last_word = (base + bpa_pkg::CNT_W'(WORD_BITS)) >= limit_reg;
    assign stat.range_err = bpa_pkg::BOUND_W'(req_reg.byte_offset) >= bound;
    assign stat.align_err = |(req_reg.byte_offset & low_mask);

    always_comb
    begin
        req_next        = req_reg;
        shift_next      = shift_reg;
        limit_next      = limit_reg;
        ptr_next        = ptr_reg;
        page_next       = page_reg;
        first_free_next = first_free_reg;
        none_free_next  = none_free_reg;
        word_valid_next = word_valid_reg;
        rsp_next        = rsp_reg;
        done_next       = 1'b0;
        ram_we          = 1'b0;
        ram_wdata       = word_data;

        if (cmd.load)
        begin
            req_next   = req;
            shift_next = eff_shift;
            limit_next = eff_limit;
            ptr_next   = none_free_reg ? '0
                         : first_free_reg[bpa_pkg::PAGE_W-1:WB_W];
        end

        if (cmd.alloc_scan)
        begin
            if (found)
            begin
                ram_we                   = 1'b1;
                ram_wdata                = word_data | (WORD_BITS'(1) << zbit);
                word_valid_next[ptr_reg] = 1'b1;
                page_next                = scan_page;
            end
            else
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end

        if (cmd.alloc_fail)
        begin
            none_free_next = 1'b1;
            rsp_next       = '{page_index: '0, page_address: '0,
                               status: bpa_pkg::ST_FULL};
            done_next      = 1'b1;
        end

        if (cmd.next_scan)
        begin
            if (found)
            begin
                first_free_next = scan_page;
                none_free_next  = 1'b0;
                rsp_next        = '{page_index: page_reg, page_address: page_addr,
                                    status: bpa_pkg::ST_OK};
                done_next       = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + PTR_W'(1);
            end
        end

        if (cmd.next_fail)
        begin
            none_free_next = 1'b1;
            rsp_next       = '{page_index: page_reg, page_address: page_addr,
                               status: bpa_pkg::ST_OK};
            done_next      = 1'b1;
        end

        if (cmd.free_check)
        begin
            page_next = free_page;
            ptr_next  = free_page[bpa_pkg::PAGE_W-1:WB_W];
        end

        if (cmd.free_err)
        begin
            rsp_next  = '{page_index: '0, page_address: '0,
                          status: stat.range_err ? bpa_pkg::ST_RANGE : bpa_pkg::ST_ALIGN};
            done_next = 1'b1;
        end

        if (cmd.free_commit)
        begin
            ram_we                   = 1'b1;
            ram_wdata                = word_data & ~(WORD_BITS'(1) << page_reg[WB_W-1:0]);
            word_valid_next[ptr_reg] = 1'b1;
            if (none_free_reg || (page_reg < first_free_reg))
            begin
                first_free_next = page_reg;
                none_free_next  = 1'b0;
            end
            rsp_next  = '{page_index: page_reg, page_address: req_reg.byte_offset,
                          status: bpa_pkg::ST_OK};
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_cfg_reg  <= bpa_pkg::RESET_SHIFT;
            pages_cfg_reg  <= bpa_pkg::RESET_PAGES;
            first_free_reg <= '0;
            none_free_reg  <= 1'b0;
            word_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    bpa_pkg::CFG_PAGE_SHIFT:   shift_cfg_reg <= cfg_data[bpa_pkg::SHIFT_W-1:0];
                    bpa_pkg::CFG_PAGES_IN_USE: pages_cfg_reg <= cfg_data;
                    default:                   ;
                endcase
            end
            first_free_reg <= first_free_next;
            none_free_reg  <= none_free_next;
            word_valid_reg <= word_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        shift_reg <= shift_next;
        limit_reg <= limit_next;
        ptr_reg   <= ptr_next;
        page_reg  <= page_next;
        rsp_reg   <= rsp_next;
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule

### hdl/bpa_controller.sv
// Controller: sequences allocate and free requests over the datapath.
module bpa_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              mode,
    input  bpa_pkg::dp_stat_t stat,
    output bpa_pkg::dp_cmd_t  cmd,
    output logic              busy
);

    bpa_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (mode == bpa_pkg::MODE_FREE) ? bpa_pkg::S_FREE_CHECK
                                                              : bpa_pkg::S_ALLOC_RD;
                end
            end
            bpa_pkg::S_ALLOC_RD:
            begin
                state_next = bpa_pkg::S_ALLOC_SCAN;
            end
            bpa_pkg::S_ALLOC_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.alloc_scan = 1'b1;
                    state_next     = bpa_pkg::S_NEXT_RD;
                end
                else if (stat.last_word)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = bpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.alloc_scan = 1'b1;
                    state_next     = bpa_pkg::S_ALLOC_RD;
                end
            end
            bpa_pkg::S_NEXT_RD:
            begin
                state_next = bpa_pkg::S_NEXT_SCAN;
            end
            bpa_pkg::S_NEXT_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.next_scan = 1'b1;
                    state_next    = bpa_pkg::S_IDLE;
                end
                else if (stat.last_word)
                begin
                    cmd.next_fail = 1'b1;
                    state_next    = bpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.next_scan = 1'b1;
                    state_next    = bpa_pkg::S_NEXT_RD;
                end
            end
            bpa_pkg::S_FREE_CHECK:
            begin
                if (stat.range_err || stat.align_err)
                begin
                    cmd.free_err = 1'b1;
                    state_next   = bpa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.free_check = 1'b1;
                    state_next     = bpa_pkg::S_FREE_RD;
                end
            end
            bpa_pkg::S_FREE_RD:
            begin
                state_next = bpa_pkg::S_FREE_COMMIT;
            end
            bpa_pkg::S_FREE_COMMIT:
            begin
                cmd.free_commit = 1'b1;
                state_next      = bpa_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != bpa_pkg::S_IDLE);

endmodule

### hdl/bitmap_page_allocator.sv
// Bitmap page allocator top level: first-fit page allocate and free.
// Allocate scans bitmap words for the first free page, then scans on for the next
//   one (both searches share the single bitmap RAM read port); a full pool ends at
//   the last word. Free checks, reads and commits; a rejected free ends at the check;
//   new requests wait for idle; done pulses for one cycle and cannot be held off.
// Reset clears per-word valid bits at once, so the bitmap reads as all free with no
//   clearing pass; configuration returns to page_shift 12 and pages_in_use 1024.
module bitmap_page_allocator #(
    parameter int WORD_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  bpa_pkg::req_t                      req,
    // result channel
    output logic                               done,
    output bpa_pkg::rsp_t                      result,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_data
);

    bpa_pkg::dp_cmd_t  cmd;
    bpa_pkg::dp_stat_t stat;
    logic              ctrl_busy;

    // The user must change configuration only while idle; the block does not enforce this and accepts every transfer.
    assign cfg_ready = 1'b1;

    // Controller: walk the scan and update states and issue the datapath commands.
    bpa_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .mode  (req.mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // Datapath: hold the bitmap, scan one word per read, register the result.
    bpa_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    assign busy = ctrl_busy;

endmodule

### hdl/bpa_checker.sv
// Port-level checker for the bitmap page allocator and its bind.
`include "bitmap_page_allocator_defines.svh"

module bpa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input bpa_pkg::rsp_t result
);

    logic rsp_err;
    logic rsp_zero;

    assign rsp_err  = (result.status != bpa_pkg::ST_OK);
    assign rsp_zero = (result.page_index == '0) && (result.page_address == '0);

    `BPA_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy, "result strobe while busy")
    `BPA_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted request not busy")
    `BPA_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe repeated")
    `BPA_ASSERT_SAME(a_err_zero, clk, rst_n, done && rsp_err, rsp_zero, "error result not zero")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### tb/sv/bitmap_page_allocator_test.sv
// Self-checking testbench of the bitmap page allocator: directed table, then random phases.
module bitmap_page_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int WORD_BITS   = 32;
    localparam int RANDOM_REQS = 1100;
    // Worst case per request is a full 32-word scan plus a
    // sender gap, so this is many times the slowest legal run.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 10;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    // One line of the directed table: either a request or a register write.
    // A request with a typed outcome is checked against that value, otherwise
    // against the allocator predictor.
    typedef struct {
        row_kind_t                kind;
        logic [CFG_IDX_W-1:0]     reg_index;
        logic [CFG_DATA_W-1:0]    reg_value;
        req_t                     request;
        bit                       typed;
        rsp_t                     outcome;
    } table_row_t;

    // ------------------------------------------------------------------
    // Block connections; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  req_in    = '0;
    logic                  done;
    rsp_t                  result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PAGE_SHIFT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Side channel from the driver to the monitor: a typed outcome rides
    // along with the request that it belongs to.
    bit   drv_typed     = 1'b0;
    rsp_t drv_typed_rsp = '0;

    bitmap_page_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req_in),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator predictor: its own bitmap, first-free pointer and registers
    // ------------------------------------------------------------------
    bit                    page_used [PAGES];
    int                    lowest_free    = 0;
    bit                    pool_exhausted = 1'b0;
    logic [SHIFT_W-1:0]    cfg_shift      = RESET_SHIFT;
    logic [CNT_W-1:0]      cfg_pages      = RESET_PAGES;

    rsp_t       awaited_results [$];
    table_row_t directed_rows [$];

    int cycle_count   = 0;
    int errors        = 0;
    int mismatches    = 0;
    int alloc_reqs    = 0;
    int free_reqs     = 0;
    int cfg_writes    = 0;
    int results_seen  = 0;
    int ok_count      = 0;
    int full_count    = 0;
    int range_count   = 0;
    int align_count   = 0;
    int phases_run    = 0;

    // Page shifts above the maximum act as the maximum.
    function automatic int eff_shift();
        return (cfg_shift > MAX_SHIFT) ? MAX_SHIFT : int'(cfg_shift);
    endfunction

    // The managed page count is clamped into [1, PAGES].
    function automatic int eff_limit();
        if (cfg_pages < 1)
            return 1;
        if (cfg_pages > PAGES)
            return PAGES;
        return int'(cfg_pages);
    endfunction

    // Lowest clear page in [from, lim); returns 0 when there is none.
    function automatic bit first_clear_page(input int from, input int lim, output int pg);
        pg = 0;
        for (int p = from; p < lim; p++)
        begin
            if (!page_used[p])
            begin
                pg = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the predictor state and return its outcome.
    function automatic rsp_t allocator_outcome(input req_t r);
        rsp_t            o;
        int              sh;
        int              lim;
        int              base;
        int              pg;
        int              nx;
        longint unsigned bound;
        longint unsigned low_bits;
        longint unsigned off;
        sh       = eff_shift();
        lim      = eff_limit();
        o        = '0;
        o.status = ST_OK;
        if (r.mode == MODE_ALLOC)
        begin
            // Once the pool ran dry, search from page 0 so that pages freed
            // or added since then are seen; otherwise from first_free's word.
            base = pool_exhausted ? 0 : (lowest_free / WORD_BITS) * WORD_BITS;
            if (!first_clear_page(base, lim, pg))
            begin
                pool_exhausted = 1'b1;
                o.status       = ST_FULL;
            end
            else
            begin
                page_used[pg]  = 1'b1;
                o.page_index   = PAGE_W'(pg);
                o.page_address = OFF_W'(longint'(pg) << sh);
                if (first_clear_page((pg / WORD_BITS) * WORD_BITS, lim, nx))
                begin
                    lowest_free    = nx;
                    pool_exhausted = 1'b0;
                end
                else
                    pool_exhausted = 1'b1;
            end
        end
        else
        begin
            off      = 64'(r.byte_offset);
            bound    = longint'(lim) << sh;
            low_bits = (64'd1 << sh) - 1;
            // Range is checked before alignment; the bound is strict.
            if (off >= bound)
                o.status = ST_RANGE;
            else if ((off & low_bits) != 0)
                o.status = ST_ALIGN;
            else
            begin
                pg            = int'(off >> sh);
                page_used[pg] = 1'b0;
                if (pool_exhausted || pg < lowest_free)
                begin
                    lowest_free    = pg;
                    pool_exhausted = 1'b0;
                end
                o.page_index   = PAGE_W'(pg);
                o.page_address = r.byte_offset;
            end
        end
        return o;
    endfunction

    function automatic rsp_t mk_rsp(input int idx, input int addr, input logic [1:0] st);
        rsp_t o;
        o.page_index   = PAGE_W'(idx);
        o.page_address = OFF_W'(addr);
        o.status       = st;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check results first, then record a newly accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_t want;
        rsp_t got;
        if (rst_n)
        begin
            if (done)
            begin
                results_seen++;
                case (result.status)
                    ST_OK:    ok_count++;
                    ST_FULL:  full_count++;
                    ST_RANGE: range_count++;
                    default:  align_count++;
                endcase
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: result with nothing awaited: ",
                                  "index %0d address 0x%07h status %0d"},
                                 result.page_index, result.page_address, result.status);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (result.page_index !== want.page_index
                        || result.page_address !== want.page_address
                        || result.status !== want.status)
                    begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result mismatch: index %0d/%0d ",
                                      "address 0x%07h/0x%07h status %0d/%0d ",
                                      "(expected/actual)"},
                                     want.page_index, result.page_index,
                                     want.page_address, result.page_address,
                                     want.status, result.status);
                    end
                end
            end
            if (start && !busy)
            begin
                got = allocator_outcome(req_in);
                awaited_results.push_back(drv_typed ? drv_typed_rsp : got);
                if (req_in.mode == MODE_ALLOC)
                    alloc_reqs++;
                else
                    free_reqs++;
            end
        end
    end

    // Watchdog: end the run if the block stops answering.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("bitmap_page_allocator test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks; inputs change on the falling edge only
    // ------------------------------------------------------------------

    // Present one request and hold it until the transfer happens.
    task automatic send_request(input req_t r, input bit typed, input rsp_t outcome);
        @(negedge clk);
        start         <= 1'b1;
        req_in        <= r;
        drv_typed     <= typed;
        drv_typed_rsp <= outcome;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Drop start and hold it low for a gap set by n.
    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // Drop start and wait until every awaited result has come back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    // One register write transfer; mirror it into the predictor on acceptance.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_PAGE_SHIFT)
            cfg_shift = val[SHIFT_W-1:0];
        else
            cfg_pages = val[CNT_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_req(input logic mode, input int off, input bit typed, input rsp_t outcome);
        table_row_t row;
        row.kind                = ROW_REQ;
        row.reg_index           = CFG_PAGE_SHIFT;
        row.reg_value           = '0;
        row.request.mode        = mode;
        row.request.byte_offset = OFF_W'(off);
        row.typed               = typed;
        row.outcome             = outcome;
        directed_rows.push_back(row);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input int val);
        table_row_t row;
        row.kind      = ROW_CFG;
        row.reg_index = idx;
        row.reg_value = CFG_DATA_W'(val);
        row.request   = '0;
        row.typed     = 1'b0;
        row.outcome   = '0;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        req_t            r;
        rsp_t            none;
        logic [OFF_W-1:0] off;
        longint unsigned bound;
        int              sh;
        int              lim;
        int              pg;
        int              c;
        int              n_items;
        int              alloc_pct;
        bit              gaps_on;
        bit              mid_drain;
        int              burst_left;
        int              rand_items;

        none = '0;

        // Directed table. Defaults after reset: page_shift 12, 1024 pages.
        push_req(MODE_ALLOC, 0, 1, mk_rsp(0, 0, ST_OK));          // first page after reset
        push_req(MODE_ALLOC, 0, 0, none);
        push_req(MODE_FREE, 26'h3FFFFFF, 1, mk_rsp(0, 0, ST_RANGE)); // largest offset
        push_req(MODE_FREE, 26'h0400000, 1, mk_rsp(0, 0, ST_RANGE)); // exactly at the bound
        push_req(MODE_FREE, 26'h03FFFFF, 1, mk_rsp(0, 0, ST_ALIGN)); // in range, inside a page
        push_req(MODE_FREE, 26'h0000001, 1, mk_rsp(0, 0, ST_ALIGN));
        push_req(MODE_FREE, 26'h0001000, 0, none);
        push_req(MODE_FREE, 26'h0001000, 0, none);                 // double free
        push_req(MODE_FREE, 26'h03FF000, 0, none);                 // last page
        // Byte-sized pages, two of them: fill up and hit full.
        push_cfg(CFG_PAGE_SHIFT, 0);
        push_cfg(CFG_PAGES_IN_USE, 2);
        push_req(MODE_ALLOC, 0, 0, none);
        push_req(MODE_ALLOC, 26'h3FFFFFF, 1, mk_rsp(0, 0, ST_FULL));
        push_req(MODE_FREE, 2, 1, mk_rsp(0, 0, ST_RANGE));
        push_req(MODE_FREE, 1, 0, none);
        // Zero pages clamps to one, and that one is in use.
        push_cfg(CFG_PAGES_IN_USE, 0);
        push_req(MODE_ALLOC, 0, 1, mk_rsp(0, 0, ST_FULL));
        // Oversized count and shift clamp to 1024 pages of 64 KiB.
        push_cfg(CFG_PAGES_IN_USE, 2047);
        push_cfg(CFG_PAGE_SHIFT, 31);
        push_req(MODE_ALLOC, 0, 0, none);
        push_req(MODE_FREE, 26'h3FF0000, 0, none);
        push_req(MODE_FREE, 26'h3FFFFFF, 1, mk_rsp(0, 0, ST_ALIGN));
        // Upper data bits of the shift register are dropped.
        push_cfg(CFG_PAGE_SHIFT, 11'h7F0);
        push_req(MODE_FREE, 26'h0010000, 0, none);
        push_req(MODE_ALLOC, 0, 0, none);

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                wait_drained();
                write_cfg(directed_rows[i].reg_index, int'(directed_rows[i].reg_value));
            end
            else
                send_request(directed_rows[i].request, directed_rows[i].typed,
                             directed_rows[i].outcome);
        end

        // Random phases: a new register setting each time, written while idle.
        rand_items = 0;
        while (rand_items < RANDOM_REQS)
        begin
            wait_drained();
            if (phases_run == 0)
            begin
                write_cfg(CFG_PAGE_SHIFT, MAX_SHIFT);
                write_cfg(CFG_PAGES_IN_USE, PAGES);
            end
            else if (phases_run == 1)
            begin
                write_cfg(CFG_PAGE_SHIFT, 0);
                write_cfg(CFG_PAGES_IN_USE, 1);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       write_cfg(CFG_PAGE_SHIFT, 0);
                    1:       write_cfg(CFG_PAGE_SHIFT, MAX_SHIFT);
                    2:       write_cfg(CFG_PAGE_SHIFT, 12);
                    3:       write_cfg(CFG_PAGE_SHIFT,
                                       int'($urandom_range(17, 31)
                                            | ($urandom_range(0, 63) << 5)));
                    default: write_cfg(CFG_PAGE_SHIFT, int'($urandom_range(0, MAX_SHIFT)));
                endcase
                // Favor small pools so that fill and full are reached often.
                case ($urandom_range(0, 7))
                    0:       write_cfg(CFG_PAGES_IN_USE, 0);
                    1:       write_cfg(CFG_PAGES_IN_USE, 1);
                    2:       write_cfg(CFG_PAGES_IN_USE, 32);
                    3:       write_cfg(CFG_PAGES_IN_USE, 33);
                    4:       write_cfg(CFG_PAGES_IN_USE, PAGES);
                    5:       write_cfg(CFG_PAGES_IN_USE, int'($urandom_range(PAGES + 1, 2047)));
                    default: write_cfg(CFG_PAGES_IN_USE, int'($urandom_range(2, 100)));
                endcase
            end
            phases_run++;

            sh         = eff_shift();
            lim        = eff_limit();
            bound      = longint'(lim) << sh;
            n_items    = $urandom_range(40, 140);
            alloc_pct  = $urandom_range(25, 85);
            gaps_on    = ($urandom_range(0, 3) != 0);
            mid_drain  = ($urandom_range(0, 2) == 0);
            burst_left = $urandom_range(1, 16);

            for (int i = 0; i < n_items; i++)
            begin
                if ($urandom_range(1, 100) <= alloc_pct)
                begin
                    // The offset is ignored on allocate; keep it random.
                    r.mode        = MODE_ALLOC;
                    r.byte_offset = OFF_W'($urandom());
                end
                else
                begin
                    r.mode = MODE_FREE;
                    // Prefer a page that is in use; else any managed page.
                    pg = $urandom_range(0, lim - 1);
                    if ($urandom_range(0, 3) != 0)
                        for (int k = 0; k < lim && !page_used[pg]; k++)
                            pg = (pg + 1) % lim;
                    c = $urandom_range(0, 9);
                    if (c <= 5)
                        off = OFF_W'(longint'(pg) << sh);
                    else if (c == 6 && bound <= 64'h3FFFFFF)
                        off = (bound + $urandom_range(0, 3) > 64'h3FFFFFF)
                              ? 26'h3FFFFFF : OFF_W'(bound + $urandom_range(0, 3));
                    else if (c == 7 && sh > 0)
                        off = OFF_W'(longint'(pg) << sh)
                              | OFF_W'($urandom_range(1, (1 << sh) - 1));
                    else
                        off = OFF_W'($urandom());
                    r.byte_offset = off;
                end
                send_request(r, 1'b0, none);
                rand_items++;

                if (mid_drain && i == n_items / 2)
                    wait_drained();
                else if (gaps_on)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        hold_off($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 16);
                    end
                end
            end
        end

        // Let the last results come home, then settle.
        wait_drained();
        repeat (SETTLE)
            @(posedge clk);
        if (awaited_results.size() != 0)
            errors++;

        $display({"Run covered %0d requests (%0d allocate, %0d free), ",
                  "%0d register writes, %0d phases."},
                 alloc_reqs + free_reqs, alloc_reqs, free_reqs, cfg_writes, phases_run);
        $display({"Results seen %0d: %0d ok, %0d full, %0d out of range, ",
                  "%0d unaligned; %0d mismatches."},
                 results_seen, ok_count, full_count, range_count, align_count, mismatches);
        if (errors == 0)
            $display("bitmap_page_allocator test passed");
        else
            $display("bitmap_page_allocator test failed");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_datapath.sv
hdl/bpa_controller.sv
hdl/bitmap_page_allocator.sv
hdl/bpa_checker.sv
tb/sv/bitmap_page_allocator_test.sv
